// ===== sv/bmhq_pkg.sv =====
// Types and constants shared by the binary max-heap queue core.
// No dependencies; compile first.
package bmhq_pkg;

	localparam int KEY_W    = 32;
	localparam int POS_W    = 6;
	localparam int MODE_W   = 2;
	localparam int TOTAL_W  = 7;
	localparam int STATUS_W = 2;

	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_MODIFY = 2'd1;
	localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;
	localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd3;

	localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

	localparam logic signed [KEY_W-1:0] KEY_MIN = 32'sh8000_0000;

	// datapath operations
	localparam logic [2:0] DP_NOP     = 3'd0;
	localparam logic [2:0] DP_LD_INS  = 3'd1;
	localparam logic [2:0] DP_LD_MOD  = 3'd2;
	localparam logic [2:0] DP_LD_REM  = 3'd3;
	localparam logic [2:0] DP_LD_KEY  = 3'd4;
	localparam logic [2:0] DP_UP_STEP = 3'd5;
	localparam logic [2:0] DP_DN_STEP = 3'd6;
	localparam logic [2:0] DP_FINAL   = 3'd7;

	// read address select
	localparam logic [1:0] RD_LAST   = 2'd0;
	localparam logic [1:0] RD_PARENT = 2'd1;
	localparam logic [1:0] RD_CHILD  = 2'd2;

	typedef struct packed {
		logic [2:0]          op;
		logic [1:0]          rd_sel;
		logic                out_ld;
		logic [STATUS_W-1:0] status;
	} bmhq_cmd_t;

	typedef struct packed {
		logic full;
		logic pos_ok;
		logic pos_last;
		logic p_root;
		logic has_left;
		logic up_gt;
		logic dn_gt;
	} bmhq_stat_t;

endpackage

// ===== sv/bmhq_item_if.sv =====
// Input channel of the heap queue: valid/ready plus one operation beat.
// Depends on bmhq_pkg.
interface bmhq_item_if import bmhq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [MODE_W-1:0]        mode;
	logic [POS_W-1:0]         position;
	logic signed [KEY_W-1:0]  key;

	modport source (output valid, mode, position, key, input ready);
	modport sink (input valid, mode, position, key, output ready);
endinterface

// ===== sv/bmhq_result_if.sv =====
// Result channel of the heap queue: valid/ready plus one result beat.
// Depends on bmhq_pkg.
interface bmhq_result_if import bmhq_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [KEY_W-1:0]  top_key;
	logic [TOTAL_W-1:0]       entry_total;
	logic [STATUS_W-1:0]      status;

	modport source (output valid, top_key, entry_total, status, input ready);
	modport sink (input valid, top_key, entry_total, status, output ready);
endinterface

// ===== sv/bmhq_ram.sv =====
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module bmhq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr0,
	input  logic [$clog2(DEPTH)-1:0] raddr1,
	output logic [WIDTH-1:0]         rdata0,
	output logic [WIDTH-1:0]         rdata1
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata0 <= mem[raddr0];
		rdata1 <= mem[raddr1];
	end
endmodule

// ===== sv/bmhq_ctrl.sv =====
// Controller FSM of the heap queue: decodes the operation, steps the sift.
// Depends on bmhq_pkg; drives bmhq_datapath through bmhq_cmd_t.
module bmhq_ctrl import bmhq_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [MODE_W-1:0] mode,
	input  bmhq_stat_t        stat,
	output logic              out_valid,
	input  logic              out_ready,
	output bmhq_cmd_t         cmd
);
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_LOAD_RD  = 4'd1;
	localparam logic [3:0] S_LOAD_KEY = 4'd2;
	localparam logic [3:0] S_UP_RD    = 4'd3;
	localparam logic [3:0] S_UP_CMP   = 4'd4;
	localparam logic [3:0] S_DN_RD    = 4'd5;
	localparam logic [3:0] S_DN_CMP   = 4'd6;
	localparam logic [3:0] S_FINAL    = 4'd7;
	localparam logic [3:0] S_DONE     = 4'd8;

	logic [3:0]          state_q, state_d;
	logic                ins_q, ins_d;     // sift up only
	logic                moved_q, moved_d; // key rose at least once
	logic [STATUS_W-1:0] st_q, st_d;
	logic                out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d    = state_q;
		ins_d      = ins_q;
		moved_d    = moved_q;
		st_d       = st_q;
		cmd.op     = DP_NOP;
		cmd.rd_sel = RD_PARENT;
		cmd.out_ld = 1'b0;
		cmd.status = st_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					st_d    = STATUS_DONE;
					ins_d   = 1'b0;
					moved_d = 1'b0;
					state_d = S_DONE;
					case (mode)
						MODE_INSERT: begin
							if (stat.full) begin
								st_d = STATUS_FULL;
							end else begin
								cmd.op  = DP_LD_INS;
								ins_d   = 1'b1;
								state_d = S_UP_RD;
							end
						end
						MODE_MODIFY: begin
							if (stat.pos_ok) begin
								cmd.op  = DP_LD_MOD;
								state_d = S_UP_RD;
							end else begin
								st_d = STATUS_RANGE;
							end
						end
						MODE_REMOVE: begin
							if (stat.pos_ok) begin
								cmd.op  = DP_LD_REM;
								state_d = stat.pos_last ? S_DONE : S_LOAD_RD;
							end else begin
								st_d = STATUS_RANGE;
							end
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_LOAD_RD: begin
				cmd.rd_sel = RD_LAST;
				state_d    = S_LOAD_KEY;
			end
			S_LOAD_KEY: begin
				cmd.op  = DP_LD_KEY;
				state_d = S_UP_RD;
			end
			S_UP_RD: begin
				cmd.rd_sel = RD_PARENT;
				if (stat.p_root) begin
					state_d = (ins_q || moved_q) ? S_FINAL : S_DN_RD;
				end else begin
					state_d = S_UP_CMP;
				end
			end
			S_UP_CMP: begin
				if (stat.up_gt) begin
					cmd.op  = DP_UP_STEP;
					moved_d = 1'b1;
					state_d = S_UP_RD;
				end else begin
					state_d = (ins_q || moved_q) ? S_FINAL : S_DN_RD;
				end
			end
			S_DN_RD: begin
				cmd.rd_sel = RD_CHILD;
				state_d    = stat.has_left ? S_DN_CMP : S_FINAL;
			end
			S_DN_CMP: begin
				if (stat.dn_gt) begin
					cmd.op  = DP_DN_STEP;
					state_d = S_DN_RD;
				end else begin
					state_d = S_FINAL;
				end
			end
			S_FINAL: begin
				cmd.op  = DP_FINAL;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_ld = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ins_q       <= 1'b0;
			moved_q     <= 1'b0;
			st_q        <= STATUS_DONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ins_q   <= ins_d;
			moved_q <= moved_d;
			st_q    <= st_d;
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end
endmodule

// ===== sv/bmhq_datapath.sv =====
// Datapath of the heap queue: key RAM, count, sift position and key, result regs.
// Depends on bmhq_pkg and bmhq_ram; commanded by bmhq_ctrl.
module bmhq_datapath import bmhq_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [POS_W-1:0]         pos,
	input  logic signed [KEY_W-1:0]  key,
	input  bmhq_cmd_t                cmd,
	output bmhq_stat_t               stat,
	output logic signed [KEY_W-1:0]  top_key,
	output logic [TOTAL_W-1:0]       entry_total,
	output logic [STATUS_W-1:0]      status
);
	localparam int AW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int EW   = AW + 2;
	localparam int CMPW = (EW > POS_W) ? EW : POS_W;

	logic [CW-1:0]           count_q;
	logic [AW-1:0]           p_q;
	logic signed [KEY_W-1:0] k_q;
	logic signed [KEY_W-1:0] top_q;
	logic signed [KEY_W-1:0] top_key_q;
	logic [TOTAL_W-1:0]      entry_total_q;
	logic [STATUS_W-1:0]     status_q;

	logic [AW-1:0]           parent;
	logic [EW-1:0]           left_w, right_w, cnt_w;
	logic                    has_right, pick_r;
	logic signed [KEY_W-1:0] key_l, key_r, pick_val;
	logic [AW-1:0]           pick_pos;
	logic [CMPW-1:0]         pos_c, cnt_c;

	logic                    we;
	logic [AW-1:0]           waddr, raddr0, raddr1;
	logic [KEY_W-1:0]        wdata, rdata0, rdata1;

	bmhq_ram #(.WIDTH(KEY_W), .DEPTH(CAPACITY)) u_ram (
		.clk    (clk),
		.we     (we),
		.waddr  (waddr),
		.wdata  (wdata),
		.raddr0 (raddr0),
		.raddr1 (raddr1),
		.rdata0 (rdata0),
		.rdata1 (rdata1)
	);

	assign key_l     = rdata0;
	assign key_r     = rdata1;
	assign parent    = (p_q - AW'(1)) >> 1;
	assign left_w    = (EW'(p_q) << 1) + EW'(1);
	assign right_w   = left_w + EW'(1);
	assign cnt_w     = EW'(count_q);
	assign has_right = right_w < cnt_w;
	// equal children: right one wins
	assign pick_r    = has_right && !(key_l > key_r);
	assign pick_val  = pick_r ? key_r : key_l;
	assign pick_pos  = pick_r ? AW'(right_w) : AW'(left_w);
	assign pos_c     = CMPW'(pos);
	assign cnt_c     = CMPW'(count_q);

	assign stat.full     = (count_q == CW'(CAPACITY));
	assign stat.pos_ok   = (pos_c < cnt_c);
	assign stat.pos_last = ((pos_c + CMPW'(1)) == cnt_c);
	assign stat.p_root   = (p_q == '0);
	assign stat.has_left = (left_w < cnt_w);
	assign stat.up_gt    = (k_q > key_l);
	assign stat.dn_gt    = (pick_val > k_q);

	assign top_key     = top_key_q;
	assign entry_total = entry_total_q;
	assign status      = status_q;

	always_comb begin
		case (cmd.rd_sel)
			RD_LAST:   raddr0 = AW'(count_q);
			RD_PARENT: raddr0 = parent;
			RD_CHILD:  raddr0 = AW'(left_w);
			default:   raddr0 = p_q;
		endcase
		raddr1 = AW'(right_w);
	end

	always_comb begin
		we    = 1'b0;
		waddr = p_q;
		wdata = k_q;
		case (cmd.op)
			DP_UP_STEP: begin
				we    = 1'b1;
				wdata = rdata0;
			end
			DP_DN_STEP: begin
				we    = 1'b1;
				wdata = pick_val;
			end
			DP_FINAL: we = 1'b1;
			default:  we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.op)
				DP_LD_INS: count_q <= count_q + CW'(1);
				DP_LD_REM: count_q <= count_q - CW'(1);
				default:   count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			DP_LD_INS: begin
				k_q <= key;
				p_q <= AW'(count_q);
			end
			DP_LD_MOD: begin
				k_q <= key;
				p_q <= AW'(pos);
			end
			DP_LD_REM:  p_q <= AW'(pos);
			DP_LD_KEY:  k_q <= key_l;
			DP_UP_STEP: p_q <= parent;
			DP_DN_STEP: p_q <= pick_pos;
			default:    p_q <= p_q;
		endcase
		// shadow of the root entry
		if (we && waddr == '0) begin
			top_q <= wdata;
		end
		if (cmd.out_ld) begin
			top_key_q     <= (count_q == '0) ? KEY_MIN : top_q;
			entry_total_q <= TOTAL_W'(count_q);
			status_q      <= cmd.status;
		end
	end
endmodule

// ===== sv/binary_max_heap_queue_core.sv =====
// Top level of the binary max-heap queue: controller plus datapath.
// Depends on bmhq_pkg, bmhq_item_if, bmhq_result_if, bmhq_ctrl, bmhq_datapath.
//
//   channel  modport  beat fields                          handshake
//   item     sink     mode, position, key                  valid/ready
//   result   source   top_key, entry_total, status         valid/ready
//
// One item is in flight at a time. Query and refused items go straight to the
// result; insert, modify and remove sift through the key RAM one tree level
// per step, each step a registered read and then a compare/write.
// Reset clears the count and control; the key RAM is not cleared.
// The result beat sits in an output register; the next item is taken while it
// waits, and the core stalls only when a second result is ready to leave.
module binary_max_heap_queue_core import bmhq_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic         clk,
	input  logic         arst_n,
	bmhq_item_if.sink    item,
	bmhq_result_if.source result
);
	bmhq_cmd_t  cmd;
	bmhq_stat_t stat;

	// FSM: decode, sift sequencing, result handshake
	bmhq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.mode      (item.mode),
		.stat      (stat),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	// key storage, count, sift state and result payload
	bmhq_datapath #(.CAPACITY(CAPACITY)) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.pos         (item.position),
		.key         (item.key),
		.cmd         (cmd),
		.stat        (stat),
		.top_key     (result.top_key),
		.entry_total (result.entry_total),
		.status      (result.status)
	);
endmodule

// ===== sv/bmhq_checker.sv =====
// Port-level checks for the heap queue core, bound to the top level.
// Depends on bmhq_pkg and binary_max_heap_queue_core.
module bmhq_checker import bmhq_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     item_valid,
	input logic                     item_ready,
	input logic                     result_valid,
	input logic                     result_ready,
	input logic signed [KEY_W-1:0]  top_key,
	input logic [TOTAL_W-1:0]       entry_total,
	input logic [STATUS_W-1:0]      status
);
	// one item at a time: ready drops after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> !item_ready)
		else $error("item accepted while another is in flight");

	a_empty_min: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && entry_total == '0 |-> top_key == KEY_MIN)
		else $error("empty heap reports a key");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && status == STATUS_FULL |-> entry_total == TOTAL_W'(CAPACITY))
		else $error("full refusal with heap not full");

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid)
		else $error("result beat dropped while stalled");
endmodule

bind binary_max_heap_queue_core bmhq_checker #(.CAPACITY(CAPACITY)) u_bmhq_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item.valid),
	.item_ready   (item.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.top_key      (result.top_key),
	.entry_total  (result.entry_total),
	.status       (result.status)
);
